// File: hdl/dblm_pkg.sv
// Package for the decaying byte-load meter: field widths, constants,
// register indexes and the sequencer state type. No dependencies.
package dblm_pkg;

   localparam int VALUE_W    = 32;
   localparam int LEVEL_W    = 22;
   localparam int LEN_W      = 16;
   localparam int SEC_W      = 32;
   localparam int USEC_W     = 20;
   localparam int PCT_W      = 7;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 20;

   // Elapsed intervals at or beyond this count clear the value
   localparam int MAX_DECAY_STEPS = 50;
   localparam int STEP_W          = $clog2(MAX_DECAY_STEPS + 1);

   localparam int PERCENT_SCALE = 100;
   localparam int LEVEL_DIVISOR = 1857;
   // 41/4096 slightly over 1/100: estimate is the true digit or one above
   localparam int RECIP_100     = 41;
   localparam int RECIP_SHIFT   = 12;

   // Product value * percent is padded to whole nibbles for the divider
   localparam int PROD_W     = VALUE_W + PCT_W;
   localparam int DIGIT_W    = 4;
   localparam int DIV_DIGITS = (PROD_W + DIGIT_W - 1) / DIGIT_W;
   localparam int SHIFT_W    = DIV_DIGITS * DIGIT_W;
   localparam int R100_W     = $clog2(PERCENT_SCALE);
   localparam int RLVL_W     = $clog2(LEVEL_DIVISOR);
   localparam int DCNT_W     = $clog2(VALUE_W);

   localparam logic [PCT_W-1:0]  DECAY_PERCENT_RESET = PCT_W'(50);
   localparam logic [USEC_W-1:0] INTERVAL_USEC_RESET = USEC_W'(1000);
   localparam logic [VALUE_W-1:0] VALUE_MAX          = '1;

   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_PERCENT = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_INTERVAL_USEC = CSR_ADDR_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUOT,
      ST_MUL,
      ST_DIV,
      ST_LVL_LOAD,
      ST_LEVEL,
      ST_DONE
   } dblm_state_type;

endpackage

// File: hdl/dblm_if.sv
// Channel interfaces of the decaying byte-load meter: request, response
// and register write. Depends on dblm_pkg for the field widths.
interface dblm_req_if import dblm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [LEN_W-1:0]     packet_length;
   logic [SEC_W-1:0]     now_seconds;
   logic [USEC_W-1:0]    now_microseconds;

   modport source (output valid, cmd, packet_length, now_seconds, now_microseconds,
                   input ready);
   modport sink   (input valid, cmd, packet_length, now_seconds, now_microseconds,
                   output ready);
endinterface

interface dblm_rsp_if import dblm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   load_value;
   logic [LEVEL_W-1:0]   load_level;

   modport source (output valid, load_value, load_level, input ready);
   modport sink   (input valid, load_value, load_level, output ready);
endinterface

interface dblm_csr_if import dblm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_ADDR_W-1:0]  addr;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// File: hdl/decaying_byte_load_meter.sv
// Top level of the decaying byte-load meter: sequencer, interval counter,
// nibble-serial decay divider and bit-serial level divider.
// Depends on dblm_pkg and the channel interfaces in dblm_if.sv.
//
//  Channel    Dir  Handshake      Beat contents
//  req_chan   in   valid/ready    cmd, packet_length, now_seconds, now_microseconds
//  rsp_chan   out  valid/ready    load_value, load_level
//  csr_chan   in   valid/ready    addr (0 decay_percent, 1 interval_usec), data
//
// A beat runs from accept to result through ST_QUOT, which finds q = elapsed /
// interval (q < 50), then q + 1 decay steps, each a multiply in ST_MUL and a
// nibble-serial radix-16 divide in ST_DIV, then a restoring divider for the
// level in ST_LEVEL. A time jump or an overrun of 50 intervals clears the value.
// Reset is synchronous; no clearing pass. The result sits in an output
// register, so the next request is taken while the last result waits.
module decaying_byte_load_meter import dblm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dblm_req_if.sink   req_chan,
   dblm_rsp_if.source rsp_chan,
   dblm_csr_if.sink   csr_chan
);

   dblm_state_type       state_ff, state_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;
   logic [USEC_W-1:0]    intv_ff, intv_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic [SEC_W-1:0]     last_s_ff, last_s_in;
   logic [USEC_W-1:0]    last_us_ff, last_us_in;
   logic [USEC_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SHIFT_W-1:0]   sh_ff, sh_in;
   logic [R100_W-1:0]    r100_ff, r100_in;
   logic [RLVL_W-1:0]    rlvl_ff, rlvl_in;
   logic [DCNT_W-1:0]    dig_ff, dig_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   out_value_ff, out_value_in;
   logic [LEVEL_W-1:0]   out_level_ff, out_level_in;

   logic [VALUE_W:0]     sum_wide;
   logic [VALUE_W-1:0]   sum_sat;
   logic [USEC_W-1:0]    intv_eff;
   logic [USEC_W-1:0]    elapsed;
   logic [PROD_W-1:0]    prod;
   logic [R100_W+DIGIT_W-1:0] div_r;
   logic [R100_W+DIGIT_W+6:0] div_est_wide;
   logic [DIGIT_W:0]     div_est;
   logic [DIGIT_W+R100_W:0] div_est_x100;
   logic [DIGIT_W-1:0]   div_q;
   logic [R100_W+DIGIT_W-1:0] div_q_x100;
   logic [SHIFT_W-1:0]   div_next;
   logic [RLVL_W:0]      lvl_t;
   logic                 lvl_ge;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.load_value = out_value_ff;
   assign rsp_chan.load_level = out_level_ff;

   always_comb begin
      sum_wide = {1'b0, acc_ff} + (VALUE_W+1)'(req_chan.packet_length);
      sum_sat  = sum_wide[VALUE_W] ? VALUE_MAX : sum_wide[VALUE_W-1:0];
      intv_eff = (intv_ff == '0) ? USEC_W'(1) : intv_ff;
      elapsed  = req_chan.now_microseconds - last_us_ff;
      prod     = PROD_W'(acc_ff) * PROD_W'(pct_ff);

      // One radix-16 digit of (value * percent) / 100
      div_r        = {r100_ff, sh_ff[SHIFT_W-1 -: DIGIT_W]};
      div_est_wide = (R100_W+DIGIT_W+7)'(div_r) * (R100_W+DIGIT_W+7)'(RECIP_100);
      div_est      = div_est_wide[RECIP_SHIFT +: DIGIT_W+1];
      div_est_x100 = (DIGIT_W+R100_W+1)'(div_est) * (DIGIT_W+R100_W+1)'(PERCENT_SCALE);
      div_q        = (div_est_x100 > (DIGIT_W+R100_W+1)'(div_r)) ?
                     DIGIT_W'(div_est - 1'b1) : div_est[DIGIT_W-1:0];
      div_q_x100   = (R100_W+DIGIT_W)'(div_q) * (R100_W+DIGIT_W)'(PERCENT_SCALE);
      div_next     = {sh_ff[SHIFT_W-DIGIT_W-1:0], div_q};

      // One bit of value / 1857
      lvl_t  = {rlvl_ff, sh_ff[VALUE_W-1]};
      lvl_ge = (lvl_t >= (RLVL_W+1)'(LEVEL_DIVISOR));
   end

   always_comb begin
      state_in     = state_ff;
      pct_in       = pct_ff;
      intv_in      = intv_ff;
      acc_in       = acc_ff;
      last_s_in    = last_s_ff;
      last_us_in   = last_us_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      sh_in        = sh_ff;
      r100_in      = r100_ff;
      rlvl_in      = rlvl_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff;
      out_value_in = out_value_ff;
      out_level_in = out_level_ff;

      if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_DECAY_PERCENT: pct_in  = csr_chan.data[PCT_W-1:0];
            CSR_INTERVAL_USEC: intv_in = csr_chan.data[USEC_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               last_s_in  = req_chan.now_seconds;
               last_us_in = req_chan.now_microseconds;
               rem_in     = elapsed;
               step_in    = '0;
               if (req_chan.now_seconds > last_s_ff ||
                   req_chan.now_microseconds < last_us_ff) begin
                  acc_in   = '0;
                  state_in = ST_LVL_LOAD;
               end else begin
                  acc_in   = (req_chan.cmd == CMD_PACKET) ? sum_sat : acc_ff;
                  state_in = ST_QUOT;
               end
            end
         end
         ST_QUOT: begin
            // step_ff counts whole intervals in the elapsed time
            if (rem_ff >= intv_eff) begin
               if (step_ff == STEP_W'(MAX_DECAY_STEPS - 1)) begin
                  acc_in   = '0;
                  state_in = ST_LVL_LOAD;
               end else begin
                  rem_in  = rem_ff - intv_eff;
                  step_in = step_ff + 1'b1;
               end
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            sh_in    = SHIFT_W'(prod);
            r100_in  = '0;
            dig_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            sh_in   = div_next;
            r100_in = R100_W'(div_r - div_q_x100);
            dig_in  = dig_ff + 1'b1;
            if (dig_ff == DCNT_W'(DIV_DIGITS - 1)) begin
               acc_in = (|div_next[SHIFT_W-1:VALUE_W]) ? VALUE_MAX : div_next[VALUE_W-1:0];
               if (step_ff == '0) begin
                  state_in = ST_LVL_LOAD;
               end else begin
                  step_in  = step_ff - 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_LVL_LOAD: begin
            sh_in    = SHIFT_W'(acc_ff);
            rlvl_in  = '0;
            dig_in   = '0;
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            rlvl_in = lvl_ge ? RLVL_W'(lvl_t - (RLVL_W+1)'(LEVEL_DIVISOR))
                             : lvl_t[RLVL_W-1:0];
            sh_in   = SHIFT_W'({sh_ff[VALUE_W-2:0], lvl_ge});
            dig_in  = dig_ff + 1'b1;
            if (dig_ff == DCNT_W'(VALUE_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_value_in = acc_ff;
               out_level_in = sh_ff[LEVEL_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pct_ff       <= DECAY_PERCENT_RESET;
         intv_ff      <= INTERVAL_USEC_RESET;
         acc_ff       <= '0;
         last_s_ff    <= '0;
         last_us_ff   <= '0;
         step_ff      <= '0;
         dig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pct_ff       <= pct_in;
         intv_ff      <= intv_in;
         acc_ff       <= acc_in;
         last_s_ff    <= last_s_in;
         last_us_ff   <= last_us_in;
         step_ff      <= step_in;
         dig_ff       <= dig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      sh_ff        <= sh_in;
      r100_ff      <= r100_in;
      rlvl_ff      <= rlvl_in;
      out_value_ff <= out_value_in;
      out_level_ff <= out_level_in;
   end

endmodule
